### rtl/grs_pkg.sv
// ----------------------------------------------------------------------------
// grs_pkg
// shared constants and types for the group reverse stream block
// ----------------------------------------------------------------------------
`default_nettype none

package grs_pkg;

  localparam int DataW    = 32;
  localparam int MaxGroup = 64;
  localparam int CntW     = $clog2(MaxGroup + 1);
  localparam int AlignW   = $clog2(MaxGroup);
  localparam int CfgW     = 7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REV,
    ST_ALIGN,
    ST_FWD
  } state_e;

  typedef enum logic [1:0] {
    SH_HOLD,
    SH_UP,
    SH_DOWN
  } shift_e;

  typedef struct packed {
    logic valid;
    logic from_top;
    logic run_last;
    logic list_end;
  } out_ctrl_t;

endpackage

`default_nettype wire

### rtl/grs_cell.sv
// ----------------------------------------------------------------------------
// grs_cell
// one word slot of the chain, loads from either neighbor or holds
// ----------------------------------------------------------------------------
`default_nettype none

module grs_cell
  import grs_pkg::*;
(
  input  wire logic             clk_i,
  input  wire shift_e           shift_i,
  input  wire logic [DataW-1:0] from_lo_i,
  input  wire logic [DataW-1:0] from_hi_i,
  output logic      [DataW-1:0] data_o
);

  logic [DataW-1:0] data_q;
  logic [DataW-1:0] data_d;

  always_comb begin
    case (shift_i)
      SH_UP:   data_d = from_lo_i;
      SH_DOWN: data_d = from_hi_i;
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

### rtl/grs_ctrl.sv
// ----------------------------------------------------------------------------
// grs_ctrl
// group size register, fill count and sequencing of the cell chain
// ----------------------------------------------------------------------------
`default_nettype none

module grs_ctrl
  import grs_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [CfgW-1:0] cfg_wdata_i,
  input  wire logic            in_valid_i,
  input  wire logic            list_end_i,
  output logic                 in_ready_o,
  input  wire logic            out_ready_i,
  output shift_e               shift_o,
  output out_ctrl_t            out_ctrl_o
);

  state_e              state_q, state_d;
  logic [CfgW-1:0]     size_q;
  logic [CntW-1:0]     fill_q, fill_d;
  logic [AlignW-1:0]   align_q, align_d;
  logic                end_q, end_d;
  logic [CntW-1:0]     eff;
  logic [CntW-1:0]     new_fill;

  always_comb begin
    if (size_q == '0) begin
      eff = CntW'(1);
    end else if (CntW'(size_q) > CntW'(MaxGroup)) begin
      eff = CntW'(MaxGroup);
    end else begin
      eff = CntW'(size_q);
    end
  end

  assign new_fill = fill_q + CntW'(1);

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    align_d    = align_q;
    end_d      = end_q;
    shift_o    = SH_HOLD;
    in_ready_o = 1'b0;
    out_ctrl_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          shift_o = SH_UP;
          end_d   = list_end_i;
          fill_d  = new_fill;
          if (new_fill >= eff) begin
            state_d = ST_REV;
          end else if (list_end_i) begin
            state_d = ST_ALIGN;
            align_d = AlignW'(CntW'(MaxGroup) - new_fill);
          end
        end
      end
      ST_REV: begin
        out_ctrl_o.valid    = 1'b1;
        out_ctrl_o.run_last = (fill_q == CntW'(1));
        out_ctrl_o.list_end = out_ctrl_o.run_last & end_q;
        if (out_ready_i) begin
          shift_o = SH_DOWN;
          fill_d  = fill_q - CntW'(1);
          if (fill_q == CntW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_ALIGN: begin
        shift_o = SH_UP;
        align_d = align_q - AlignW'(1);
        if (align_q == AlignW'(1)) begin
          state_d = ST_FWD;
        end
      end
      ST_FWD: begin
        out_ctrl_o.valid    = 1'b1;
        out_ctrl_o.from_top = 1'b1;
        out_ctrl_o.run_last = (fill_q == CntW'(1));
        out_ctrl_o.list_end = out_ctrl_o.run_last;
        if (out_ready_i) begin
          shift_o = SH_UP;
          fill_d  = fill_q - CntW'(1);
          if (fill_q == CntW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      size_q  <= CfgW'(1);
      fill_q  <= '0;
      align_q <= '0;
      end_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      align_q <= align_d;
      end_q   <= end_d;
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
    end
  end

  a_idle_no_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_ctrl_o.valid)
    else $error("output valid while taking input");

  a_idle_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> fill_q < CntW'(MaxGroup))
    else $error("fill count overrun while idle");

  a_last_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ctrl_o.valid && out_ready_i && out_ctrl_o.run_last
    |=> state_q == ST_IDLE && fill_q == '0)
    else $error("buffer not empty after last result");

  a_align_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ALIGN && align_q == AlignW'(1) |=> state_q == ST_FWD)
    else $error("alignment did not hand over to drain");

endmodule

`default_nettype wire

### rtl/group_reverse_stream_top.sv
// ----------------------------------------------------------------------------
// group_reverse_stream_top
// buffers words in a chain of cells and emits full groups reversed,
// a trailing partial group in arrival order
// ----------------------------------------------------------------------------
// channel   signals                                  direction
// in        in_valid_i in_ready_o word_i list_end_i  sink
// out       out_valid_o out_ready_i out_word_o
//           run_last_o out_list_end_o                source
// cfg       cfg_we_i cfg_wdata_i                     sink, no wait
//
// an item is taken while idle and pushed into cell 0 of a 64 cell chain
// a full group then leaves one result per cycle from cell 0 while out_ready_i
// is high; a trailing partial group of n words first shifts up by 64 - n
// cells, then leaves one result per cycle from cell 63 while out_ready_i is high
// no new item is taken while results are pending; a stalled output holds
// reset empties the buffer and sets the group size to 1
// ----------------------------------------------------------------------------
`default_nettype none

module group_reverse_stream_top
  import grs_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgW-1:0]    cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [DataW-1:0] word_i,
  input  wire logic               list_end_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [DataW-1:0] out_word_o,
  output logic                    run_last_o,
  output logic                    out_list_end_o
);

  shift_e           shift;
  out_ctrl_t        oc;
  logic [DataW-1:0] cell_data [MaxGroup];

  grs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .list_end_i  (list_end_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .shift_o     (shift),
    .out_ctrl_o  (oc)
  );

  for (genvar i = 0; i < MaxGroup; i++) begin : g_cell
    logic [DataW-1:0] lo;
    logic [DataW-1:0] hi;
    if (i == 0) begin : g_first
      assign lo = $unsigned(word_i);
    end else begin : g_lo
      assign lo = cell_data[i-1];
    end
    if (i == MaxGroup - 1) begin : g_last
      assign hi = '0;
    end else begin : g_hi
      assign hi = cell_data[i+1];
    end
    grs_cell u_cell (
      .clk_i     (clk_i),
      .shift_i   (shift),
      .from_lo_i (lo),
      .from_hi_i (hi),
      .data_o    (cell_data[i])
    );
  end

  assign out_valid_o    = oc.valid;
  assign out_word_o     = $signed(oc.from_top ? cell_data[MaxGroup-1] : cell_data[0]);
  assign run_last_o     = oc.run_last;
  assign out_list_end_o = oc.list_end;

endmodule

`default_nettype wire

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for group_reverse_stream_top: words go in as lists
// under several group sizes, from pass-through up to saturated groups of 64;
// a scoreboard predicts the reordered output and checks every result item
// ----------------------------------------------------------------------------
`default_nettype none

module tb
  import grs_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 1_000_000;
  localparam int SettleCycles = 80;

  typedef struct packed {
    logic signed [DataW-1:0] word;
    logic                    run_last;
    logic                    list_end;
  } emitted_t;

  class reorder_tracker;
    logic [CfgW-1:0]         group_size;
    logic signed [DataW-1:0] held_words [MaxGroup];
    int                      held_count;
    emitted_t                due_q [$];
    int                      mismatches;
    int                      checked;

    function new();
      group_size = 1;
      held_count = 0;
      mismatches = 0;
      checked    = 0;
    endfunction

    function void set_group_size(logic [CfgW-1:0] v);
      group_size = v;
    endfunction

    function void take_word(logic signed [DataW-1:0] w, logic is_end);
      int eff;
      emitted_t r;
      eff = int'(group_size);
      if (eff < 1) eff = 1;
      if (eff > MaxGroup) eff = MaxGroup;
      held_words[held_count] = w;
      held_count++;
      if (held_count >= eff) begin
        for (int i = held_count; i > 0; i--) begin
          r.word     = held_words[i-1];
          r.run_last = (i == 1);
          r.list_end = (i == 1) && is_end;
          due_q.push_back(r);
        end
        held_count = 0;
      end else if (is_end) begin
        // trailing partial group keeps arrival order
        for (int i = 0; i < held_count; i++) begin
          r.word     = held_words[i];
          r.run_last = (i + 1 == held_count);
          r.list_end = (i + 1 == held_count);
          due_q.push_back(r);
        end
        held_count = 0;
      end
    endfunction

    function void check_emitted(emitted_t got);
      emitted_t exp_r;
      checked++;
      if (due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: word %0d run_last %0b list_end %0b",
                   got.word, got.run_last, got.list_end);
        return;
      end
      exp_r = due_q.pop_front();
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected word %0d last %0b end %0b, got word %0d last %0b end %0b",
                   exp_r.word, exp_r.run_last, exp_r.list_end,
                   got.word, got.run_last, got.list_end);
      end
    endfunction

    function int pending();
      return due_q.size();
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [CfgW-1:0]         cfg_wdata_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic signed [DataW-1:0] word_i = '0;
  logic                    list_end_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic signed [DataW-1:0] out_word_o;
  logic                    run_last_o;
  logic                    out_list_end_o;

  reorder_tracker tracker = new();

  int          cycle_count = 0;
  int          items_sent = 0;
  int          burst_left = 0;
  bit          steady = 1'b1;
  logic [15:0] stall_pattern = 16'h5a5b;

  group_reverse_stream_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .word_i         (word_i),
    .list_end_i     (list_end_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_word_o     (out_word_o),
    .run_last_o     (run_last_o),
    .out_list_end_o (out_list_end_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver stalls follow a rotating pattern, reloaded now and then
  always @(negedge clk_i) begin
    if (cycle_count % 256 == 0)
      stall_pattern <= ($urandom_range(0, 3) == 0) ? 16'hffff : (16'($urandom) | 16'h0001);
    else
      stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
    out_ready_i <= steady || stall_pattern[0];
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      tracker.check_emitted({out_word_o, run_last_o, out_list_end_o});
  end

  task automatic send_word(input logic signed [DataW-1:0] w, input logic is_end);
    int gap;
    if (!steady && burst_left == 0) begin
      gap = $urandom_range(0, 6);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    word_i     <= w;
    list_end_i <= is_end;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.take_word(w, is_end);
    items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_group_size(input logic [CfgW-1:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    tracker.set_group_size(v);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [CfgW-1:0] phase_sizes [10];
    int eff;
    int n_items;
    int list_left;
    logic is_end;

    phase_sizes = '{7'd2, 7'd3, 7'd0, 7'd64, 7'd5, 7'd1, 7'd127, 7'd4, 7'd7, 7'd6};

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // pass-through at the reset group size, extreme words
    send_word(32'sh7fffffff, 1'b0);
    send_word(32'sh80000000, 1'b1);
    wait_drained();
    write_group_size(7'd0);
    send_word(-32'sd1, 1'b0);
    send_word(32'sd0, 1'b1);
    wait_drained();
    // full group reversed, then a partial group in order
    write_group_size(7'd3);
    send_word(32'sd11, 1'b0);
    send_word(32'sd12, 1'b0);
    send_word(32'sd13, 1'b0);
    send_word(32'sd14, 1'b0);
    send_word(32'sd15, 1'b1);
    wait_drained();
    // group completes on the list end word
    write_group_size(7'd2);
    send_word(32'sh55555555, 1'b0);
    send_word(32'shaaaaaaaa, 1'b1);
    wait_drained();
    // size lowered below the number of words already held
    write_group_size(7'd5);
    send_word(32'sd21, 1'b0);
    send_word(32'sd22, 1'b0);
    send_word(32'sd23, 1'b0);
    wait_drained();
    write_group_size(7'd2);
    send_word(32'sd24, 1'b0);
    wait_drained();
    // oversized group saturates, single word list
    write_group_size(7'd127);
    send_word(32'sd31, 1'b1);
    wait_drained();

    for (int ph = 0; ph < 10; ph++) begin
      write_group_size(phase_sizes[ph]);
      steady = (ph % 3 == 0);
      burst_left = 0;
      eff = int'(phase_sizes[ph]);
      if (eff < 1) eff = 1;
      if (eff > MaxGroup) eff = MaxGroup;
      n_items = (eff >= MaxGroup) ? 70 : 16;
      list_left = 0;
      for (int k = 0; k < n_items; k++) begin
        if (list_left == 0)
          list_left = (eff >= MaxGroup) ? $urandom_range(60, 72) : $urandom_range(1, 3 * eff + 1);
        // mostly whole lists, sometimes cut short
        is_end = (list_left == 1) || ($urandom_range(0, 19) == 0);
        list_left = is_end ? 0 : list_left - 1;
        send_word($urandom, is_end);
      end
      wait_drained();
    end

    $display("sent %0d items over directed cases and 10 random phases", items_sent);
    $display("group sizes 0 to 127 incl. saturation, %0d results checked",
             tracker.checked);
    if (tracker.mismatches == 0 && tracker.pending() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire

### group_reverse_stream_top.f
rtl/grs_pkg.sv
rtl/grs_cell.sv
rtl/grs_ctrl.sv
rtl/group_reverse_stream_top.sv
tb/tb.sv
